// ===== hdl/m2h_pkg.sv =====
package m2h_pkg;

	// Mixing constants of 32-bit MurmurHash2.
	localparam logic [31:0] MIX_MUL     = 32'h5bd1_e995;
	localparam int          MIX_SHIFT   = 24;
	localparam int          FIN_SHIFT_A = 13;
	localparam int          FIN_SHIFT_B = 15;
	localparam logic [31:0] SEED_RESET  = 32'd5381;

	// Packed input word layout.
	localparam int WORD_W   = 32;
	localparam int COUNT_W  = 3;
	localparam int LEN_W    = 32;
	localparam int IN_BITS  = WORD_W + COUNT_W + LEN_W;
	localparam int IN_TDATA_W = ((IN_BITS + 7) / 8) * 8;
	localparam int COUNT_LO = WORD_W;
	localparam int LEN_LO   = WORD_W + COUNT_W;

	// Operand selection of the shared multiplier.
	typedef enum logic [2:0] {
		OP_K1   = 3'd0,
		OP_K2   = 3'd1,
		OP_H    = 3'd2,
		OP_TAIL = 3'd3,
		OP_FIN  = 3'd4
	} op_t;

	typedef struct packed {
		logic load;
		logic mul_en;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic in_first;
		logic in_full;
		logic in_empty;
		logic in_last;
		logic last_q;
		logic out_busy;
	} sts_t;

endpackage

// ===== hdl/m2h_ctrl.sv =====
module m2h_ctrl
	import m2h_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  sts_t sts,
	output cmd_t cmd
);

	typedef enum logic [5:0] {
		ST_IDLE = 6'b000001,
		ST_K1   = 6'b000010,
		ST_K2   = 6'b000100,
		ST_KH   = 6'b001000,
		ST_TAIL = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	state_t state_q, state_nxt;
	logic   in_key_q;

	assign in_ready = (state_q == ST_IDLE);

	always_comb begin
		state_nxt  = state_q;
		cmd.load   = 1'b0;
		cmd.mul_en = 1'b0;
		cmd.op     = OP_K1;
		unique case (state_q)
			ST_IDLE: begin
				// Words outside an open key are taken and dropped.
				if (in_valid && (sts.in_first || in_key_q)) begin
					cmd.load = 1'b1;
					if (sts.in_full) begin
						state_nxt = ST_K1;
					end else if (!sts.in_empty) begin
						state_nxt = ST_TAIL;
					end else if (sts.in_last) begin
						state_nxt = ST_FIN;
					end
				end
			end
			ST_K1: begin
				cmd.mul_en = 1'b1;
				cmd.op     = OP_K1;
				state_nxt  = ST_K2;
			end
			ST_K2: begin
				cmd.mul_en = 1'b1;
				cmd.op     = OP_K2;
				state_nxt  = ST_KH;
			end
			ST_KH: begin
				cmd.mul_en = 1'b1;
				cmd.op     = OP_H;
				state_nxt  = sts.last_q ? ST_FIN : ST_IDLE;
			end
			ST_TAIL: begin
				cmd.mul_en = 1'b1;
				cmd.op     = OP_TAIL;
				state_nxt  = sts.last_q ? ST_FIN : ST_IDLE;
			end
			ST_FIN: begin
				if (!sts.out_busy) begin
					cmd.mul_en = 1'b1;
					cmd.op     = OP_FIN;
					state_nxt  = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			in_key_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load) begin
				in_key_q <= 1'b1;
			end else if (cmd.mul_en && (cmd.op == OP_FIN)) begin
				in_key_q <= 1'b0;
			end
		end
	end

endmodule

// ===== hdl/m2h_dp.sv =====
module m2h_dp
	import m2h_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  cmd_t                cmd,
	output sts_t                sts,
	input  logic                cfg_valid,
	input  logic [31:0]         cfg_data,
	input  logic [WORD_W-1:0]   data_word,
	input  logic [COUNT_W-1:0]  byte_count,
	input  logic [LEN_W-1:0]    key_length,
	input  logic                first,
	input  logic                last,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [31:0]         out_hash
);

	logic [31:0] seed_q;
	logic [31:0] h_q;
	logic [31:0] k_q;
	logic [31:0] w_q;
	logic [31:0] mask_q;
	logic        last_q;
	logic        out_valid_q;
	logic [31:0] out_hash_q;

	logic [31:0] mask_in;
	logic [31:0] mul_a;
	logic [31:0] prod;
	logic [31:0] fin_h;

	// Byte mask for a short word; only used when the count is 1 to 3.
	always_comb begin
		unique case (byte_count[1:0])
			2'd1:    mask_in = 32'h0000_00ff;
			2'd2:    mask_in = 32'h0000_ffff;
			2'd3:    mask_in = 32'h00ff_ffff;
			default: mask_in = 32'hffff_ffff;
		endcase
	end

	always_comb begin
		unique case (cmd.op)
			OP_K1:   mul_a = w_q;
			OP_K2:   mul_a = k_q ^ (k_q >> MIX_SHIFT);
			OP_H:    mul_a = h_q;
			OP_TAIL: mul_a = h_q ^ (w_q & mask_q);
			OP_FIN:  mul_a = h_q ^ (h_q >> FIN_SHIFT_A);
			default: mul_a = h_q;
		endcase
	end

	assign prod  = mul_a * MIX_MUL;
	assign fin_h = prod ^ (prod >> FIN_SHIFT_B);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_q      <= SEED_RESET;
			h_q         <= '0;
			last_q      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				seed_q <= cfg_data;
			end
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (cmd.load) begin
				if (first) begin
					h_q <= seed_q ^ key_length;
				end
				last_q <= last;
			end else if (cmd.mul_en) begin
				unique case (cmd.op)
					OP_H:    h_q <= prod ^ k_q;
					OP_TAIL: h_q <= prod;
					OP_FIN: begin
						h_q         <= fin_h;
						out_valid_q <= 1'b1;
					end
					default: h_q <= h_q;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			w_q    <= data_word;
			mask_q <= mask_in;
		end
		if (cmd.mul_en && (cmd.op == OP_K1 || cmd.op == OP_K2)) begin
			k_q <= prod;
		end
		if (cmd.mul_en && cmd.op == OP_FIN) begin
			out_hash_q <= fin_h;
		end
	end

	assign sts.in_first = first;
	assign sts.in_full  = byte_count[COUNT_W-1];
	assign sts.in_empty = (byte_count == '0);
	assign sts.in_last  = last;
	assign sts.last_q   = last_q;
	assign sts.out_busy = out_valid_q && !out_ready;

	assign out_valid = out_valid_q;
	assign out_hash  = out_hash_q;

endmodule

// ===== hdl/murmur2_hash32.sv =====
// Channel   Direction  Word contents
// s_axis    in         tdata: data_word[31:0], byte_count[34:32], key_length[66:35], zeros;
//                      tuser: first; tlast: last
// m_axis    out        tdata: hash[31:0]
// cfg       in         cfg_data: seed[31:0]
//
// One input word is taken at a time. A word with four bytes is accepted and then
// mixed by three passes through the single 32x32 multiplier, a word with one to
// three bytes by one tail pass, an empty word by none; a last word adds one
// more multiplier pass for the finish step. The shared multiplier sets the rate.
// Reset clears the open-key flag, the running hash and the output valid, and loads
// the seed with 5381. The finish step waits while an earlier hash is unread.
module murmur2_hash32
	import m2h_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	input  logic [IN_TDATA_W-1:0] s_axis_tdata,  // data_word, byte_count, key_length, pad
	input  logic                  s_axis_tuser,  // first
	input  logic                  s_axis_tlast,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	output logic [31:0]           m_axis_tdata,  // hash
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [31:0]           cfg_data       // seed
);

	cmd_t cmd;
	sts_t sts;
	logic ctrl_ready;

	// The seed register takes a write in any cycle.
	assign cfg_ready     = 1'b1;
	assign s_axis_tready = ctrl_ready;

	// The controller sequences the multiplier passes for each word and
	// tracks whether a key is open.
	m2h_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (ctrl_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// The datapath holds the running hash, the mixing register, the seed,
	// and the output register that lets a finished hash wait for the sink.
	m2h_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.sts        (sts),
		.cfg_valid  (cfg_valid),
		.cfg_data   (cfg_data),
		.data_word  (s_axis_tdata[WORD_W-1:0]),
		.byte_count (s_axis_tdata[COUNT_LO +: COUNT_W]),
		.key_length (s_axis_tdata[LEN_LO +: LEN_W]),
		.first      (s_axis_tuser),
		.last       (s_axis_tlast),
		.out_valid  (m_axis_tvalid),
		.out_ready  (m_axis_tready),
		.out_hash   (m_axis_tdata)
	);

	// A full word that opens a key keeps the input stalled while it is mixed.
	a_full_word_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && s_axis_tuser
			&& s_axis_tdata[COUNT_LO + COUNT_W - 1]) |=> !s_axis_tready)
		else $error("input not stalled after a full first word");

	// A dropped word, outside any key, leaves the block ready.
	a_drop_stays_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready && !cmd.load) |=> s_axis_tready)
		else $error("dropped word started work");

	// A hash only appears after a finish pass of the multiplier.
	a_out_from_finish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(cmd.mul_en && cmd.op == OP_FIN))
		else $error("hash presented without a finish step");

endmodule
